### rtl/gdn_pkg.sv
// Package for the Gregorian day number unit: operation codes, constants, stage tags and tables.
`timescale 1ns / 1ps

package gdn_pkg;

    // Operation codes carried in s_tuser
    typedef enum logic [1:0] {
        OP_DAY_NUM    = 2'd0,
        OP_DISTANCE   = 2'd1,
        OP_ADD_OFFSET = 2'd2,
        OP_TO_DATE    = 2'd3
    } op_t;

    // Field widths
    localparam int unsigned YEAR_W  = 15;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned DVAL_W  = 24;
    localparam int unsigned COUNT_W = 23;
    localparam int unsigned JDN_W   = 26;

    // Supported day number span: -4700-01-01 to 9999-12-31
    localparam logic signed [JDN_W-1:0] SPAN_LOW  = 26'sd4421;
    localparam logic signed [JDN_W-1:0] SPAN_HIGH = 26'sd5373484;

    // Year + 4800 plus 12000 (a multiple of 400) keeps the shifted year positive
    localparam logic signed [16:0] YEAR_BIAS = 17'sd16800;
    // Folds -32045 and the corrections for the 12000 year bias
    localparam logic [JDN_W-1:0]   JDN_BIAS  = 26'd4414955;
    localparam logic [JDN_W-1:0]   EPOCH_OFS = 26'd32044;

    // Reciprocals for the constant divisions
    localparam logic [15:0] RECIP_25     = 16'd41944;     // 2^20 / 25, rounded up
    localparam logic [24:0] RECIP_146097 = 25'd30103606;  // 2^42 / 146097, rounded up
    localparam logic [18:0] RECIP_1461   = 19'd367469;    // 2^29 / 1461, rounded up
    localparam logic [11:0] RECIP_153    = 12'd3427;      // 2^19 / 153, rounded up

    // Request tag carried down the front stages
    typedef struct packed {
        op_t  op;
        logic earlier;
        logic same;
    } req_tag_t;

    // Result tag carried down the back stages
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               err;
        logic               make_date;
        logic               earlier;
        logic               same;
    } res_tag_t;

    // Month index counted from March: Jan/Feb become 10/11 of the previous year
    function automatic logic [3:0] march_month(logic [MONTH_W-1:0] month);
        logic [3:0] m;
        if (month <= 4'd2) begin
            m = month + 4'd9;
        end else begin
            m = month - 4'd3;
        end
        return m;
    endfunction

    // Days from March 1 to the start of March-based month m: (153*m + 2) / 5
    function automatic logic [8:0] month_offset(logic [3:0] m);
        logic [8:0] ofs;
        case (m)
            4'd0:    ofs = 9'd0;
            4'd1:    ofs = 9'd31;
            4'd2:    ofs = 9'd61;
            4'd3:    ofs = 9'd92;
            4'd4:    ofs = 9'd122;
            4'd5:    ofs = 9'd153;
            4'd6:    ofs = 9'd184;
            4'd7:    ofs = 9'd214;
            4'd8:    ofs = 9'd245;
            4'd9:    ofs = 9'd275;
            4'd10:   ofs = 9'd306;
            4'd11:   ofs = 9'd337;
            4'd12:   ofs = 9'd367;
            default: ofs = 9'd0;
        endcase
        return ofs;
    endfunction

    // Year shifted to March-based counting plus bias; always in 415..33183
    function automatic logic [15:0] shifted_year(logic signed [YEAR_W-1:0] year,
                                                 logic [MONTH_W-1:0] month);
        logic signed [16:0] sum;
        sum = 17'(year) + YEAR_BIAS - ((month <= 4'd2) ? 17'sd1 : 17'sd0);
        return sum[15:0];
    endfunction

    // Day number from shifted year, its year/100 product and the day-in-year sum
    function automatic logic signed [JDN_W-1:0] day_number(logic [15:0] yp,
                                                           logic [29:0] prod,
                                                           logic [9:0]  dsum);
        logic [9:0]       q100;
        logic [JDN_W-1:0] acc;
        q100 = prod[29:20];
        acc  = JDN_W'(yp) * 26'd365 + JDN_W'(yp[15:2]) - JDN_W'(q100)
             + JDN_W'(q100[9:2]) + JDN_W'(dsum) - JDN_BIAS;
        return signed'(acc);
    endfunction

    function automatic logic in_span(logic signed [JDN_W-1:0] j);
        return (j >= SPAN_LOW) && (j <= SPAN_HIGH);
    endfunction

endpackage

### rtl/gregorian_day_number_unit.sv
// Top level of the Gregorian day number unit: pipelined date and day number arithmetic.
`timescale 1ns / 1ps

// Channel  | Ports                          | Contents
// ---------+--------------------------------+----------------------------------------
// request  | s_tvalid s_tready s_tdata/tuser| op code, dates A and B, day value
// result   | m_tvalid m_tready m_tdata/tuser| day count, date, order flags, range error
//
// One request is taken every cycle while the result register is empty or taken.
// The ten-stage pipeline holds the request register, two stages per date-to-number
// conversion, the operation select, one per number-to-date step and the result register.
// All stages advance together whenever the result register is empty or taken,
// so a stalled result holds the whole pipeline and s_tready follows it.
// Reset (aresetn low, synchronous) clears every stage valid bit and m_tvalid.

module gregorian_day_number_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // a_year[14:0], a_month[18:15], a_day[23:19], b_year[38:24],
    // b_month[42:39], b_day[47:43], day_value[71:48]
    input  logic [71:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // day_count[22:0], out_year[37:23], out_month[41:38], out_day[46:42],
    // a_before_b[47], a_same_as_b[48], zero fill [55:49]
    output logic [55:0] m_tdata,
    // range_error[0]
    output logic        m_tuser
);

    localparam int unsigned NSTAGE = 9;

    // Pipeline control
    logic              adv;
    logic [NSTAGE-1:0] vld_reg;
    logic              m_tvalid_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg      <= {vld_reg[NSTAGE-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[NSTAGE-1];
        end
    end

    // Stage 0: request register
    gdn_pkg::op_t                       op0_reg;
    logic signed [gdn_pkg::YEAR_W-1:0]  ay0_reg, by0_reg;
    logic [gdn_pkg::MONTH_W-1:0]        am0_reg, bm0_reg;
    logic [gdn_pkg::DAY_W-1:0]          ad0_reg, bd0_reg;
    logic signed [gdn_pkg::DVAL_W-1:0]  dv0_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            op0_reg <= gdn_pkg::op_t'(s_tuser);
            ay0_reg <= s_tdata[14:0];
            am0_reg <= s_tdata[18:15];
            ad0_reg <= s_tdata[23:19];
            by0_reg <= s_tdata[38:24];
            bm0_reg <= s_tdata[42:39];
            bd0_reg <= s_tdata[47:43];
            dv0_reg <= s_tdata[71:48];
        end
    end

    // Stage 1: shifted years, year/100 reciprocal products, day-in-year sums, order flags
    logic [15:0]                       ya_sh, yb_sh;
    logic [15:0]                       ypa1_reg, ypb1_reg;
    logic [29:0]                       pra1_reg, prb1_reg;
    logic [9:0]                        dsa1_reg, dsb1_reg;
    logic signed [gdn_pkg::DVAL_W-1:0] dv1_reg;
    gdn_pkg::req_tag_t                 tag1_next, tag1_reg;

    assign ya_sh = gdn_pkg::shifted_year(ay0_reg, am0_reg);
    assign yb_sh = gdn_pkg::shifted_year(by0_reg, bm0_reg);

    always_comb begin
        tag1_next.op      = op0_reg;
        tag1_next.earlier = (ay0_reg < by0_reg)
                         || ((ay0_reg == by0_reg) && (am0_reg < bm0_reg))
                         || ((ay0_reg == by0_reg) && (am0_reg == bm0_reg)
                             && (ad0_reg < bd0_reg));
        tag1_next.same    = (ay0_reg == by0_reg) && (am0_reg == bm0_reg)
                         && (ad0_reg == bd0_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ypa1_reg <= ya_sh;
            ypb1_reg <= yb_sh;
            pra1_reg <= 30'(ya_sh[15:2]) * 30'(gdn_pkg::RECIP_25);
            prb1_reg <= 30'(yb_sh[15:2]) * 30'(gdn_pkg::RECIP_25);
            dsa1_reg <= 10'(gdn_pkg::month_offset(gdn_pkg::march_month(am0_reg)))
                      + 10'(ad0_reg);
            dsb1_reg <= 10'(gdn_pkg::month_offset(gdn_pkg::march_month(bm0_reg)))
                      + 10'(bd0_reg);
            dv1_reg  <= dv0_reg;
            tag1_reg <= tag1_next;
        end
    end

    // Stage 2: day numbers of A and B
    logic signed [gdn_pkg::JDN_W-1:0]  ja2_reg, jb2_reg;
    logic signed [gdn_pkg::DVAL_W-1:0] dv2_reg;
    gdn_pkg::req_tag_t                 tag2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            ja2_reg  <= gdn_pkg::day_number(ypa1_reg, pra1_reg, dsa1_reg);
            jb2_reg  <= gdn_pkg::day_number(ypb1_reg, prb1_reg, dsb1_reg);
            dv2_reg  <= dv1_reg;
            tag2_reg <= tag1_reg;
        end
    end

    // Stage 3: operation select, span checks, distance, epoch shift
    logic signed [gdn_pkg::JDN_W-1:0] dv_ext, target, diff;
    logic [gdn_pkg::JDN_W-1:0]        a_shift;
    logic [22:0]                      a3_reg;
    gdn_pkg::res_tag_t                res3_next, res3_reg;

    assign dv_ext  = gdn_pkg::JDN_W'(dv2_reg);
    assign diff    = ja2_reg - jb2_reg;
    assign target  = (tag2_reg.op == gdn_pkg::OP_ADD_OFFSET) ? (ja2_reg + dv_ext) : dv_ext;
    assign a_shift = unsigned'(target) + gdn_pkg::EPOCH_OFS;

    always_comb begin
        res3_next.count     = '0;
        res3_next.err       = 1'b0;
        res3_next.make_date = 1'b0;
        res3_next.earlier   = tag2_reg.earlier;
        res3_next.same      = tag2_reg.same;
        unique case (tag2_reg.op)
            gdn_pkg::OP_DAY_NUM: begin
                if (gdn_pkg::in_span(ja2_reg)) begin
                    res3_next.count = ja2_reg[gdn_pkg::COUNT_W-1:0];
                end else begin
                    res3_next.err = 1'b1;
                end
            end
            gdn_pkg::OP_DISTANCE: begin
                if (gdn_pkg::in_span(ja2_reg) && gdn_pkg::in_span(jb2_reg)) begin
                    res3_next.count = diff[gdn_pkg::JDN_W-1] ?
                                      gdn_pkg::COUNT_W'(-diff) : gdn_pkg::COUNT_W'(diff);
                end else begin
                    res3_next.err = 1'b1;
                end
            end
            gdn_pkg::OP_ADD_OFFSET: begin
                if (gdn_pkg::in_span(ja2_reg) && gdn_pkg::in_span(target)) begin
                    res3_next.make_date = 1'b1;
                end else begin
                    res3_next.err = 1'b1;
                end
            end
            gdn_pkg::OP_TO_DATE: begin
                if (gdn_pkg::in_span(target)) begin
                    res3_next.make_date = 1'b1;
                end else begin
                    res3_next.err = 1'b1;
                end
            end
            default: begin
                res3_next.err = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a3_reg   <= a_shift[22:0];
            res3_reg <= res3_next;
        end
    end

    // Stage 4: 400-year cycles, b = (4a + 3) / 146097
    logic [49:0]       prod_b;
    logic [22:0]       a4_reg;
    logic [7:0]        b4_reg;
    gdn_pkg::res_tag_t res4_reg;

    assign prod_b = 50'({a3_reg, 2'b11}) * 50'(gdn_pkg::RECIP_146097);

    always_ff @(posedge aclk) begin
        if (adv) begin
            a4_reg   <= a3_reg;
            b4_reg   <= prod_b[49:42];
            res4_reg <= res3_reg;
        end
    end

    // Stage 5: day within the 400-year cycle, c = a - 146097 * b / 4
    logic [24:0]       cyc_days;
    logic [22:0]       c_full;
    logic [15:0]       c5_reg;
    logic [7:0]        b5_reg;
    gdn_pkg::res_tag_t res5_reg;

    assign cyc_days = 25'(b4_reg) * 25'd146097;
    assign c_full   = a4_reg - cyc_days[24:2];

    always_ff @(posedge aclk) begin
        if (adv) begin
            c5_reg   <= c_full[15:0];
            b5_reg   <= b4_reg;
            res5_reg <= res4_reg;
        end
    end

    // Stage 6: years in the cycle, d = (4c + 3) / 1461
    logic [36:0]       prod_d;
    logic [15:0]       c6_reg;
    logic [7:0]        b6_reg, d6_reg;
    gdn_pkg::res_tag_t res6_reg;

    assign prod_d = 37'({c5_reg, 2'b11}) * 37'(gdn_pkg::RECIP_1461);

    always_ff @(posedge aclk) begin
        if (adv) begin
            c6_reg   <= c5_reg;
            b6_reg   <= b5_reg;
            d6_reg   <= prod_d[36:29];
            res6_reg <= res5_reg;
        end
    end

    // Stage 7: day within the March-based year, e = c - 1461 * d / 4
    logic [17:0]       yr_days;
    logic [15:0]       e_full;
    logic [8:0]        e7_reg;
    logic [7:0]        b7_reg, d7_reg;
    gdn_pkg::res_tag_t res7_reg;

    assign yr_days = 18'(d6_reg) * 18'd1461;
    assign e_full  = c6_reg - yr_days[17:2];

    always_ff @(posedge aclk) begin
        if (adv) begin
            e7_reg   <= e_full[8:0];
            b7_reg   <= b6_reg;
            d7_reg   <= d6_reg;
            res7_reg <= res6_reg;
        end
    end

    // Stage 8: March-based month, m = (5e + 2) / 153
    logic [10:0]       n_m;
    logic [22:0]       prod_m;
    logic [8:0]        e8_reg;
    logic [7:0]        b8_reg, d8_reg;
    logic [3:0]        m8_reg;
    gdn_pkg::res_tag_t res8_reg;

    assign n_m    = 11'(e7_reg) * 11'd5 + 11'd2;
    assign prod_m = 23'(n_m) * 23'(gdn_pkg::RECIP_153);

    always_ff @(posedge aclk) begin
        if (adv) begin
            e8_reg   <= e7_reg;
            b8_reg   <= b7_reg;
            d8_reg   <= d7_reg;
            m8_reg   <= prod_m[22:19];
            res8_reg <= res7_reg;
        end
    end

    // Result: calendar date assembly and result register
    logic                               late;
    logic [9:0]                         day_full;
    logic [15:0]                        year_full;
    logic [gdn_pkg::MONTH_W-1:0]        month_calc;
    logic [gdn_pkg::COUNT_W-1:0]        count_reg;
    logic signed [gdn_pkg::YEAR_W-1:0]  year_reg;
    logic [gdn_pkg::MONTH_W-1:0]        month_reg;
    logic [gdn_pkg::DAY_W-1:0]          day_reg;
    logic                               before_reg, same_reg, err_reg;

    assign late       = (m8_reg >= 4'd10);
    assign day_full   = 10'(e8_reg) - 10'(gdn_pkg::month_offset(m8_reg)) + 10'd1;
    assign month_calc = late ? (m8_reg - 4'd9) : (m8_reg + 4'd3);
    assign year_full  = 16'(b8_reg) * 16'd100 + 16'(d8_reg) + 16'(late) - 16'd4800;

    always_ff @(posedge aclk) begin
        if (adv) begin
            count_reg  <= res8_reg.count;
            before_reg <= res8_reg.earlier;
            same_reg   <= res8_reg.same;
            err_reg    <= res8_reg.err;
            if (res8_reg.make_date) begin
                year_reg  <= year_full[gdn_pkg::YEAR_W-1:0];
                month_reg <= month_calc;
                day_reg   <= day_full[gdn_pkg::DAY_W-1:0];
            end else begin
                year_reg  <= '0;
                month_reg <= '0;
                day_reg   <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, same_reg, before_reg, day_reg, month_reg, year_reg, count_reg};
    assign m_tuser  = err_reg;

    // Checks
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_err_no_date: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && err_reg |-> (year_reg == '0) && (month_reg == '0) && (day_reg == '0))
        else $error("date fields set on a range error");

    a_err_no_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && err_reg |-> (count_reg == '0))
        else $error("day count set on a range error");

    a_date_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (month_reg != '0) |-> (month_reg <= 4'd12) && (day_reg != '0)
                                          && (count_reg == '0))
        else $error("illegal result date");

    a_order_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(before_reg && same_reg))
        else $error("A both before and same as B");

endmodule
